>>> rtl/segment_intersection_test_assert.svh
// Assertion macros shared by the segment intersection RTL.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef SEGMENT_INTERSECTION_TEST_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_ASSERT_SVH
`ifndef SYNTHESIS
`define SIT_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SIT_ASSERT_IMPLY(lbl, ante, cons, msg)
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/sit_pkg.sv
package sit_pkg;

   typedef struct packed {
      logic signed [31:0] start_a_x;
      logic signed [31:0] start_a_y;
      logic signed [31:0] dir_a_x;
      logic signed [31:0] dir_a_y;
      logic signed [31:0] start_b_x;
      logic signed [31:0] start_b_y;
      logic signed [31:0] dir_b_x;
      logic signed [31:0] dir_b_y;
   } req_type;

   typedef enum logic [1:0] {
      REL_CROSS     = 2'd0,
      REL_PARALLEL  = 2'd1,
      REL_COLLINEAR = 2'd2
   } relation_type;

   typedef struct packed {
      logic         hit;
      relation_type relation;
   } rsp_type;

   // Degenerate-vector flags carried alongside the arithmetic.
   typedef struct packed {
      logic a_zero;
      logic b_zero;
      logic d_zero;
   } flags_type;

   // Slots of the prepared vector word.
   localparam int VEC_N = 6;
   localparam int V_AX  = 0;
   localparam int V_AY  = 1;
   localparam int V_BX  = 2;
   localparam int V_BY  = 3;
   localparam int V_DX  = 4;
   localparam int V_DY  = 5;

   // Products: each slot multiplies PROD_L by PROD_R.
   localparam int PROD_N  = 16;
   localparam int P_AXBY  = 0;
   localparam int P_AYBX  = 1;
   localparam int P_DXAY  = 2;
   localparam int P_DYAX  = 3;
   localparam int P_DXBY  = 4;
   localparam int P_DYBX  = 5;
   localparam int P_AXAX  = 6;
   localparam int P_AYAY  = 7;
   localparam int P_DXAX  = 8;
   localparam int P_DYAY  = 9;
   localparam int P_BXAX  = 10;
   localparam int P_BYAY  = 11;
   localparam int P_DXBX  = 12;
   localparam int P_DYBY  = 13;
   localparam int P_BXBX  = 14;
   localparam int P_BYBY  = 15;

   localparam int PROD_L [PROD_N] = '{V_AX, V_AY, V_DX, V_DY, V_DX, V_DY, V_AX, V_AY,
                                      V_DX, V_DY, V_BX, V_BY, V_DX, V_DY, V_BX, V_BY};
   localparam int PROD_R [PROD_N] = '{V_BY, V_BX, V_AY, V_AX, V_BY, V_BX, V_AX, V_AY,
                                      V_AX, V_AY, V_AX, V_AY, V_BX, V_BY, V_BX, V_BY};

   // Cross products and dot products formed from the products.
   localparam int SUM_N = 8;
   localparam int S_DEN = 0;
   localparam int S_CA  = 1;
   localparam int S_NT  = 2;
   localparam int S_AA  = 3;
   localparam int S_S0  = 4;
   localparam int S_S1  = 5;
   localparam int S_DDB = 6;
   localparam int S_BB  = 7;

endpackage

>>> rtl/sit_prep.sv
module sit_prep import sit_pkg::*; #(
   parameter int CB = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_stall,
   input  req_type                    in_data,
   output logic                       out_valid,
   input  logic                       out_stall,
   output logic [VEC_N-1:0][CB:0]     out_vec
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [VEC_N-1:0][CB:0] vec_ff;
   logic [VEC_N-1:0][CB:0] vec_in;
   logic [CB:0]            sax;
   logic [CB:0]            say;
   logic [CB:0]            sbx;
   logic [CB:0]            sby;

   // Only the low CB bits of each coordinate count; extend one bit so the
   // start offset below is exact.
   assign sax = {in_data.start_a_x[CB-1], in_data.start_a_x[CB-1:0]};
   assign say = {in_data.start_a_y[CB-1], in_data.start_a_y[CB-1:0]};
   assign sbx = {in_data.start_b_x[CB-1], in_data.start_b_x[CB-1:0]};
   assign sby = {in_data.start_b_y[CB-1], in_data.start_b_y[CB-1:0]};

   always_comb begin
      vec_in[V_AX] = {in_data.dir_a_x[CB-1], in_data.dir_a_x[CB-1:0]};
      vec_in[V_AY] = {in_data.dir_a_y[CB-1], in_data.dir_a_y[CB-1:0]};
      vec_in[V_BX] = {in_data.dir_b_x[CB-1], in_data.dir_b_x[CB-1:0]};
      vec_in[V_BY] = {in_data.dir_b_y[CB-1], in_data.dir_b_y[CB-1:0]};
      vec_in[V_DX] = sbx - sax;
      vec_in[V_DY] = sby - say;
   end

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

>>> rtl/sit_mul.sv
module sit_mul import sit_pkg::*; #(
   parameter int CB = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_stall,
   input  logic [VEC_N-1:0][CB:0]         in_vec,
   output logic                           out_valid,
   input  logic                           out_stall,
   output logic [PROD_N-1:0][2*CB+3:0]    out_prod,
   output flags_type                      out_flags
);

   localparam int W  = 2 * CB + 4;
   localparam int PW = 2 * CB + 2;

   logic                       valid_ff;
   logic                       valid_in;
   logic [PROD_N-1:0][W-1:0]   prod_ff;
   logic [PROD_N-1:0][W-1:0]   prod_in;
   flags_type                  flags_ff;
   flags_type                  flags_in;

   for (genvar i = 0; i < PROD_N; i++) begin : g_prod
      logic signed [PW-1:0] p;
      assign p          = $signed(in_vec[PROD_L[i]]) * $signed(in_vec[PROD_R[i]]);
      assign prod_in[i] = {{(W-PW){p[PW-1]}}, p};
   end

   always_comb begin
      flags_in.a_zero = (in_vec[V_AX] == '0) && (in_vec[V_AY] == '0);
      flags_in.b_zero = (in_vec[V_BX] == '0) && (in_vec[V_BY] == '0);
      flags_in.d_zero = (in_vec[V_DX] == '0) && (in_vec[V_DY] == '0);
   end

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         prod_ff  <= prod_in;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;
   assign out_flags = flags_ff;

endmodule

>>> rtl/sit_sum.sv
module sit_sum import sit_pkg::*; #(
   parameter int CB = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_stall,
   input  logic [PROD_N-1:0][2*CB+3:0]    in_prod,
   input  flags_type                      in_flags,
   output logic                           out_valid,
   input  logic                           out_stall,
   output logic [SUM_N-1:0][2*CB+3:0]     out_sum,
   output flags_type                      out_flags
);

   localparam int W = 2 * CB + 4;

   logic                     valid_ff;
   logic                     valid_in;
   logic [SUM_N-1:0][W-1:0]  sum_ff;
   logic [SUM_N-1:0][W-1:0]  sum_in;
   flags_type                flags_ff;

   // Every term is at most 2^(2*CB) in magnitude, so no sum here can wrap.
   always_comb begin
      sum_in[S_DEN] = in_prod[P_AXBY] - in_prod[P_AYBX];
      sum_in[S_CA]  = in_prod[P_DXAY] - in_prod[P_DYAX];
      sum_in[S_NT]  = in_prod[P_DXBY] - in_prod[P_DYBX];
      sum_in[S_AA]  = in_prod[P_AXAX] + in_prod[P_AYAY];
      sum_in[S_S0]  = in_prod[P_DXAX] + in_prod[P_DYAY];
      sum_in[S_S1]  = in_prod[P_DXAX] + in_prod[P_DYAY]
                    + in_prod[P_BXAX] + in_prod[P_BYAY];
      sum_in[S_DDB] = in_prod[P_DXBX] + in_prod[P_DYBY];
      sum_in[S_BB]  = in_prod[P_BXBX] + in_prod[P_BYBY];
   end

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         sum_ff   <= sum_in;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_sum   = sum_ff;
   assign out_flags = flags_ff;

endmodule

>>> rtl/sit_dec.sv
module sit_dec import sit_pkg::*; #(
   parameter int CB = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_stall,
   input  logic [SUM_N-1:0][2*CB+3:0]     in_sum,
   input  flags_type                      in_flags,
   output logic                           out_valid,
   input  logic                           out_stall,
   output rsp_type                        out_data
);

   localparam int W = 2 * CB + 4;

   logic                valid_ff;
   logic                valid_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic signed [W-1:0] den;
   logic signed [W-1:0] ca;
   logic signed [W-1:0] nt;
   logic signed [W-1:0] aa;
   logic signed [W-1:0] s0;
   logic signed [W-1:0] s1;
   logic signed [W-1:0] ddb;
   logic signed [W-1:0] bb;
   logic signed [W-1:0] ddb_bb;
   logic                t_ok;
   logic                u_ok;
   logic                proj_ok;
   logic                point_ok;

   always_comb begin
      den    = $signed(in_sum[S_DEN]);
      ca     = $signed(in_sum[S_CA]);
      nt     = $signed(in_sum[S_NT]);
      aa     = $signed(in_sum[S_AA]);
      s0     = $signed(in_sum[S_S0]);
      s1     = $signed(in_sum[S_S1]);
      ddb    = $signed(in_sum[S_DDB]);
      bb     = $signed(in_sum[S_BB]);
      ddb_bb = ddb + bb;
   end

   // With a negative denominator the bounds flip instead of negating.
   always_comb begin
      if (den[W-1]) begin
         t_ok = (nt <= 0) && (nt >= den);
         u_ok = (ca <= 0) && (ca >= den);
      end else begin
         t_ok = (nt >= 0) && (nt <= den);
         u_ok = (ca >= 0) && (ca <= den);
      end
      // The interval [min(s0,s1), max(s0,s1)] must meet [0, aa].
      proj_ok  = ((s0 <= aa) || (s1 <= aa)) && ((s0 >= 0) || (s1 >= 0));
      // A is a point: it must lie on B, between B's ends.
      point_ok = (nt == 0) && (ddb <= 0) && (ddb_bb >= 0);
   end

   always_comb begin
      if (den != 0) begin
         rsp_in.relation = REL_CROSS;
         rsp_in.hit      = t_ok && u_ok;
      end else if (ca != 0) begin
         rsp_in.relation = REL_PARALLEL;
         rsp_in.hit      = 1'b0;
      end else begin
         rsp_in.relation = REL_COLLINEAR;
         if (!in_flags.a_zero) begin
            rsp_in.hit = proj_ok;
         end else if (!in_flags.b_zero) begin
            rsp_in.hit = point_ok;
         end else begin
            rsp_in.hit = in_flags.d_zero;
         end
      end
   end

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

>>> rtl/segment_intersection_test.sv
// Exact 2D segment intersection test. Each request beat carries two segments, each as a
// start point and a direction vector in signed Q16.16; only the low COORD_BITS bits of each
// coordinate are used, sign-extended. One response beat per request gives hit and a relation
// code (crossing lines, parallel disjoint lines, or collinear). All arithmetic is exact with
// no division, so touching end points count as hits. The block is a four-stage pipeline
// that takes one beat every cycle while the response side does not stall. Each request is
// registered in turn by the prep, product, sum and decision stages. The stall from
// the response side travels back through the stages, so a bubble anywhere in the pipeline
// still lets a new request in.
`include "segment_intersection_test_assert.svh"

module segment_intersection_test import sit_pkg::*; #(
   parameter int COORD_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int W = 2 * COORD_BITS + 4;

   // Stage 1 registers the sign-extended directions and the start offset.
   logic                           prep_valid;
   logic                           prep_stall;
   logic [VEC_N-1:0][COORD_BITS:0] prep_vec;

   // Stage 2 registers all sixteen products side by side.
   logic                           mul_valid;
   logic                           mul_stall;
   logic [PROD_N-1:0][W-1:0]       mul_prod;
   flags_type                      mul_flags;

   // Stage 3 registers the cross and dot products.
   logic                           sum_valid;
   logic                           sum_stall;
   logic [SUM_N-1:0][W-1:0]        sum_val;
   flags_type                      sum_flags;

   // Short names for the conditions that the checks below watch.
   logic                           req_take;
   logic                           rsp_held;
   logic                           rsp_parallel;
   logic                           rsp_code_known;

   sit_prep #(.CB(COORD_BITS)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .out_stall (prep_stall),
      .out_vec   (prep_vec)
   );

   sit_mul #(.CB(COORD_BITS)) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_stall  (prep_stall),
      .in_vec    (prep_vec),
      .out_valid (mul_valid),
      .out_stall (mul_stall),
      .out_prod  (mul_prod),
      .out_flags (mul_flags)
   );

   sit_sum #(.CB(COORD_BITS)) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_stall  (mul_stall),
      .in_prod   (mul_prod),
      .in_flags  (mul_flags),
      .out_valid (sum_valid),
      .out_stall (sum_stall),
      .out_sum   (sum_val),
      .out_flags (sum_flags)
   );

   // Stage 4 makes the decision and is also the response register.
   sit_dec #(.CB(COORD_BITS)) u_dec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_stall  (sum_stall),
      .in_sum    (sum_val),
      .in_flags  (sum_flags),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign req_take       = req_valid && !req_stall;
   assign rsp_held       = rsp_valid && rsp_stall;
   assign rsp_parallel   = rsp_valid && (rsp_data.relation == REL_PARALLEL);
   assign rsp_code_known = rsp_data.relation inside {REL_CROSS, REL_PARALLEL, REL_COLLINEAR};

   // The request side can only be held off when every stage is occupied.
   `SIT_ASSERT_IMPLY(a_stall_only_when_full, req_stall, rsp_held, "stall with room left")
   // An accepted request always lands in the first stage.
   `SIT_ASSERT_NEXT(a_accept_fills_prep, req_take, prep_valid, "accepted request beat lost")
   // Parallel lines that are not the same line never meet.
   `SIT_ASSERT_IMPLY(a_parallel_no_hit, rsp_parallel, !rsp_data.hit, "hit on parallel lines")
   // Only the three defined relation codes leave the block.
   `SIT_ASSERT_IMPLY(a_relation_code, rsp_valid, rsp_code_known, "undefined relation code")

endmodule
